// ===== hdl/cdt_pkg.sv =====
// Shared types, constants and helpers for the countdown timer bank.
// Used by every module of the block; no dependencies of its own.
package cdt_pkg;

  localparam int TIMER_COUNT = 16;
  localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int RIDX_W      = 4;
  localparam int DATA_W      = 32;

  typedef logic [IDX_W-1:0] tidx_t;

  typedef enum logic [1:0] {
    MODE_UNUSED  = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_RUNNING = 2'd2
  } tmode_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_SET   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_EMIT,
    ST_ALLOC,
    ST_RESP
  } state_t;

  typedef struct packed {
    tmode_t            mode;
    logic [DATA_W-1:0] remaining;
    logic [DATA_W-1:0] reload;
    logic [DATA_W-1:0] repeats;
  } entry_t;

  // Write request into the timer store.
  typedef struct packed {
    logic   en;
    logic   mode_only;
    tidx_t  idx;
    entry_t data;
  } wr_t;

  // Status from the controller, watched at the top level.
  typedef struct packed {
    logic              out_load;
    logic [DATA_W-1:0] tick_count;
  } stat_t;

  // Timer index to the result field: low bits, zero-extended if narrower.
  function automatic logic [RIDX_W-1:0] to_ridx(input tidx_t i);
    logic [IDX_W+RIDX_W-1:0] tmp;
    tmp = '0;
    tmp[IDX_W-1:0] = i;
    return tmp[RIDX_W-1:0];
  endfunction

  // Input index field to a timer index.
  function automatic tidx_t to_tidx(input logic [RIDX_W-1:0] v);
    logic [IDX_W+RIDX_W-1:0] tmp;
    tmp = '0;
    tmp[RIDX_W-1:0] = v;
    return tmp[IDX_W-1:0];
  endfunction

endpackage

// ===== hdl/cdt_store.sv =====
// Timer state store: per-timer mode, remaining count, reload value and repeats.
// One write port and one read port; depends on cdt_pkg.
module cdt_store import cdt_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  wr_t    wr,
  input  tidx_t  rd_idx,
  output entry_t rd_data
);

  tmode_t            mode_r [TIMER_COUNT];
  logic [DATA_W-1:0] rem_r  [TIMER_COUNT];
  logic [DATA_W-1:0] rel_r  [TIMER_COUNT];
  logic [DATA_W-1:0] rep_r  [TIMER_COUNT];

  // Counters are only meaningful once a set has loaded them, so only the
  // modes need a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < TIMER_COUNT; j++) begin
        mode_r[j] <= MODE_UNUSED;
      end
    end else if (wr.en) begin
      mode_r[wr.idx] <= wr.data.mode;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && !wr.mode_only) begin
      rem_r[wr.idx] <= wr.data.remaining;
      rel_r[wr.idx] <= wr.data.reload;
      rep_r[wr.idx] <= wr.data.repeats;
    end
  end

  always_comb begin
    rd_data.mode      = mode_r[rd_idx];
    rd_data.remaining = rem_r[rd_idx];
    rd_data.reload    = rel_r[rd_idx];
    rd_data.repeats   = rep_r[rd_idx];
  end

endmodule

// ===== hdl/cdt_unit.sv =====
// Shared update unit: advances one timer entry by one tick.
// One decrement-and-compare on the count plus the repeat bookkeeping; uses cdt_pkg.
module cdt_unit import cdt_pkg::*; (
  input  entry_t cur,
  output entry_t nxt,
  output logic   expire
);

  logic [DATA_W-1:0] dec;

  assign dec = cur.remaining - DATA_W'(1);

  always_comb begin
    nxt    = cur;
    expire = 1'b0;
    if (cur.mode == MODE_RUNNING) begin
      nxt.remaining = dec;
      if (dec == '0) begin
        expire = 1'b1;
        if (cur.repeats == '0) begin
          nxt.mode = MODE_ALLOC;
        end else begin
          nxt.repeats   = cur.repeats - DATA_W'(1);
          nxt.remaining = cur.reload;
        end
      end
    end
  end

endmodule

// ===== hdl/cdt_ctrl.sv =====
// Sequencer of the timer bank: command decode, entry sweep, expiry emission
// and the output register. Drives the timer store and the update unit; uses cdt_pkg.
module cdt_ctrl import cdt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic [RIDX_W-1:0] in_timer_index,
  input  logic [DATA_W-1:0] in_timeout_ticks,
  input  logic [DATA_W-1:0] in_repeat_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RIDX_W-1:0] out_result_index,
  output logic              out_expired,
  output logic              out_status,
  output logic [DATA_W-1:0] out_tick_total,
  output logic              out_last,
  output tidx_t             rd_idx,
  input  entry_t            rd_data,
  input  entry_t            upd_data,
  input  logic              upd_expire,
  output wr_t               wr,
  output stat_t             stat
);

  state_t                 state_r, state_nxt;
  tidx_t                  idx_r, idx_nxt;
  logic [TIMER_COUNT-1:0] mask_r, mask_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [DATA_W-1:0]      tick_r, tick_nxt;
  logic [RIDX_W-1:0]      resp_idx_r, resp_idx_nxt;
  logic                   resp_fail_r, resp_fail_nxt;

  logic                   out_valid_r;
  logic [RIDX_W-1:0]      out_result_index_r, out_result_index_nxt;
  logic                   out_expired_r, out_expired_nxt;
  logic                   out_status_r, out_status_nxt;
  logic [DATA_W-1:0]      out_tick_total_r;
  logic                   out_last_r, out_last_nxt;
  logic                   out_load;

  logic                   accept;
  logic                   out_free;
  logic                   last_idx;
  logic                   idx_ok;
  logic [TIMER_COUNT-1:0] sel;
  logic [TIMER_COUNT-1:0] above;
  logic                   bit_hit;
  logic                   more_above;
  logic                   emit_last;
  logic [TIMER_COUNT-1:0] mask_upd;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign last_idx = (idx_r == IDX_W'(TIMER_COUNT - 1));
  assign idx_ok   = (DATA_W'(in_timer_index) < DATA_W'(TIMER_COUNT));

  always_comb begin
    for (int j = 0; j < TIMER_COUNT; j++) begin
      sel[j]   = (IDX_W'(j) == idx_r);
      above[j] = (j > int'(idx_r));
    end
  end

  assign bit_hit    = |(mask_r & sel);
  assign more_above = |(mask_r & above);
  // The last reported expiry is the highest one, or the one that fills the
  // result budget of this tick.
  assign emit_last  = !more_above || (cnt_r == CNT_W'(MAX_RESULTS - 1));
  assign mask_upd   = mask_r | (sel & {TIMER_COUNT{upd_expire}});

  // Next state and sequencer registers.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    mask_nxt      = mask_r;
    cnt_nxt       = cnt_r;
    tick_nxt      = tick_r;
    resp_idx_nxt  = resp_idx_r;
    resp_fail_nxt = resp_fail_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(in_command))
            CMD_TICK: begin
              tick_nxt  = tick_r + DATA_W'(1);
              idx_nxt   = '0;
              mask_nxt  = '0;
              state_nxt = ST_TICK;
            end
            CMD_ALLOC: begin
              idx_nxt   = '0;
              state_nxt = ST_ALLOC;
            end
            CMD_FREE, CMD_SET: begin
              resp_idx_nxt  = '0;
              resp_fail_nxt = 1'b0;
              state_nxt     = ST_RESP;
            end
          endcase
        end
      end
      ST_TICK: begin
        mask_nxt = mask_upd;
        if (last_idx) begin
          idx_nxt = '0;
          cnt_nxt = '0;
          if (mask_upd == '0) begin
            resp_idx_nxt  = '0;
            resp_fail_nxt = 1'b0;
            state_nxt     = ST_RESP;
          end else begin
            state_nxt = ST_EMIT;
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_EMIT: begin
        if (bit_hit) begin
          if (out_free) begin
            cnt_nxt = cnt_r + CNT_W'(1);
            if (emit_last) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_ALLOC: begin
        if (rd_data.mode == MODE_UNUSED) begin
          resp_idx_nxt  = to_ridx(idx_r);
          resp_fail_nxt = 1'b0;
          state_nxt     = ST_RESP;
        end else if (last_idx) begin
          resp_idx_nxt  = '0;
          resp_fail_nxt = 1'b1;
          state_nxt     = ST_RESP;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs: handshake, store access and the next result.
  always_comb begin
    in_stall             = (state_r != ST_IDLE);
    rd_idx               = idx_r;
    wr                   = '0;
    wr.idx               = idx_r;
    wr.data              = rd_data;
    out_load             = 1'b0;
    out_result_index_nxt = '0;
    out_expired_nxt      = 1'b0;
    out_status_nxt       = 1'b0;
    out_last_nxt         = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && idx_ok) begin
          if (cmd_t'(in_command) == CMD_FREE) begin
            wr.en        = 1'b1;
            wr.mode_only = 1'b1;
            wr.idx       = to_tidx(in_timer_index);
            wr.data.mode = MODE_UNUSED;
          end else if (cmd_t'(in_command) == CMD_SET) begin
            wr.en             = 1'b1;
            wr.idx            = to_tidx(in_timer_index);
            wr.data.mode      = MODE_RUNNING;
            wr.data.remaining = in_timeout_ticks;
            wr.data.reload    = in_timeout_ticks;
            wr.data.repeats   = in_repeat_count;
          end
        end
      end
      ST_TICK: begin
        wr.en   = 1'b1;
        wr.data = upd_data;
      end
      ST_EMIT: begin
        if (bit_hit && out_free) begin
          out_load             = 1'b1;
          out_result_index_nxt = to_ridx(idx_r);
          out_expired_nxt      = 1'b1;
          out_last_nxt         = emit_last;
        end
      end
      ST_ALLOC: begin
        if (rd_data.mode == MODE_UNUSED) begin
          wr.en             = 1'b1;
          wr.data.mode      = MODE_ALLOC;
          wr.data.remaining = '0;
          wr.data.reload    = '0;
          wr.data.repeats   = '0;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_result_index_nxt = resp_idx_r;
          out_status_nxt       = resp_fail_r;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      mask_r      <= '0;
      cnt_r       <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      mask_r  <= mask_nxt;
      cnt_r   <= cnt_nxt;
      tick_r  <= tick_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    resp_idx_r  <= resp_idx_nxt;
    resp_fail_r <= resp_fail_nxt;
    if (out_load) begin
      out_result_index_r <= out_result_index_nxt;
      out_expired_r      <= out_expired_nxt;
      out_status_r       <= out_status_nxt;
      out_tick_total_r   <= tick_r;
      out_last_r         <= out_last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_result_index_r;
  assign out_expired      = out_expired_r;
  assign out_status       = out_status_r;
  assign out_tick_total   = out_tick_total_r;
  assign out_last         = out_last_r;

  assign stat.out_load   = out_load;
  assign stat.tick_count = tick_r;

endmodule

// ===== hdl/countdown_timer_bank_top.sv =====
// Top level of the countdown timer bank: sequencer, timer store and update unit.
// Depends on cdt_pkg, cdt_store, cdt_unit and cdt_ctrl.
//
// A bank of TIMER_COUNT countdown timers served one command at a time through
// one read port and one write port on the timer store and one shared
// decrement unit. A tick sweeps every timer, one per cycle, then walks the
// index range once more to report expiries, one result per cycle while the
// output is not stalled; when nothing expires, a single result follows the
// sweep instead. Allocate searches from timer 0 upward, one timer per cycle,
// and answers from the response state once the search stops. Free and set
// write the store when accepted with an index in range and answer from the
// response state. The input is stalled while a command is in progress; a
// finished result may wait in the output register while the next command is
// taken. Timer modes reset directly, so the bank is ready right after reset.
module countdown_timer_bank_top import cdt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic [RIDX_W-1:0] in_timer_index,
  input  logic [DATA_W-1:0] in_timeout_ticks,
  input  logic [DATA_W-1:0] in_repeat_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RIDX_W-1:0] out_result_index,
  output logic              out_expired,
  output logic              out_status,
  output logic [DATA_W-1:0] out_tick_total,
  output logic              out_last
);

  tidx_t  rd_idx;
  entry_t rd_data;
  entry_t upd_data;
  logic   upd_expire;
  wr_t    wr;
  stat_t  stat;

  cdt_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  cdt_unit u_unit (
    .cur    (rd_data),
    .nxt    (upd_data),
    .expire (upd_expire)
  );

  cdt_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_timer_index   (in_timer_index),
    .in_timeout_ticks (in_timeout_ticks),
    .in_repeat_count  (in_repeat_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_index (out_result_index),
    .out_expired      (out_expired),
    .out_status       (out_status),
    .out_tick_total   (out_tick_total),
    .out_last         (out_last),
    .rd_idx           (rd_idx),
    .rd_data          (rd_data),
    .upd_data         (upd_data),
    .upd_expire       (upd_expire),
    .wr               (wr),
    .stat             (stat)
  );

  // The tick count moves only right after a tick command is transferred.
  a_tick_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (stat.tick_count != $past(stat.tick_count)))
      |-> $past(in_valid && !in_stall && (in_command == CMD_TICK)))
    else $error("tick count changed without a tick command");

  // A new result never overwrites one that is still waiting for transfer.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stat.out_load |-> !(out_valid && out_stall))
    else $error("output register loaded while a result was pending");

  // An expiry report never carries an allocation failure.
  a_expired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_expired) |-> !out_status)
    else $error("expired result with failure status");

endmodule

// ===== tb/sv/countdown_timer_bank_top_tb.sv =====
// Self-checking testbench for countdown_timer_bank_top: directed and random commands
// are checked against a cycle-free predictor of the timer bank.
// Depends on cdt_pkg and the countdown_timer_bank_top RTL.
`timescale 1ns / 1ps

module countdown_timer_bank_top_tb;
  import cdt_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 150;

  typedef struct packed {
    cmd_t              cmd;
    logic [RIDX_W-1:0] idx;
    logic [DATA_W-1:0] timeout;
    logic [DATA_W-1:0] repeats;
  } timer_cmd_t;

  typedef struct packed {
    logic [RIDX_W-1:0] ridx;
    logic              expired;
    logic              status;
    logic [DATA_W-1:0] ticks;
    logic              last;
  } timer_result_t;

  typedef enum int {STALL_OPEN, STALL_CHOPPY, STALL_HELD} stall_kind_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_command = CMD_TICK;
  logic [RIDX_W-1:0] in_timer_index = '0;
  logic [DATA_W-1:0] in_timeout_ticks = '0;
  logic [DATA_W-1:0] in_repeat_count = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [RIDX_W-1:0] out_result_index;
  logic              out_expired;
  logic              out_status;
  logic [DATA_W-1:0] out_tick_total;
  logic              out_last;

  timer_cmd_t    cmd_backlog[$];
  timer_result_t due_results[$];
  int            fail_count = 0;
  int            idle_cycles = 0;

  // Predictor copy of the timer bank.
  tmode_t            mode_q[TIMER_COUNT];
  logic [DATA_W-1:0] remain_q[TIMER_COUNT];
  logic [DATA_W-1:0] reload_q[TIMER_COUNT];
  logic [DATA_W-1:0] repeats_q[TIMER_COUNT];
  logic [DATA_W-1:0] ticks_seen;

  countdown_timer_bank_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_timer_index   (in_timer_index),
    .in_timeout_ticks (in_timeout_ticks),
    .in_repeat_count  (in_repeat_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_index (out_result_index),
    .out_expired      (out_expired),
    .out_status       (out_status),
    .out_tick_total   (out_tick_total),
    .out_last         (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Updates the predicted bank for one command and queues the results it causes.
  task automatic apply_command(input timer_cmd_t c);
    int n;
    int slot;
    n = 0;
    slot = -1;
    case (c.cmd)
      CMD_TICK: begin
        ticks_seen = ticks_seen + 1;
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (mode_q[i] == MODE_RUNNING) begin
            remain_q[i] = remain_q[i] - 1;
            if (remain_q[i] == '0) begin
              if (repeats_q[i] == '0) begin
                mode_q[i] = MODE_ALLOC;
              end else begin
                repeats_q[i] = repeats_q[i] - 1;
                remain_q[i] = reload_q[i];
              end
              if (n < MAX_RESULTS) begin
                due_results.push_back('{RIDX_W'(i), 1'b1, 1'b0, ticks_seen, 1'b0});
                n++;
              end
            end
          end
        end
        if (n == 0) begin
          due_results.push_back('{'0, 1'b0, 1'b0, ticks_seen, 1'b1});
        end else begin
          due_results[due_results.size() - 1].last = 1'b1;
        end
      end
      CMD_ALLOC: begin
        for (int i = TIMER_COUNT - 1; i >= 0; i--) begin
          if (mode_q[i] == MODE_UNUSED) slot = i;
        end
        if (slot < 0) begin
          due_results.push_back('{'0, 1'b0, 1'b1, ticks_seen, 1'b1});
        end else begin
          mode_q[slot] = MODE_ALLOC;
          remain_q[slot] = '0;
          reload_q[slot] = '0;
          repeats_q[slot] = '0;
          due_results.push_back('{RIDX_W'(slot), 1'b0, 1'b0, ticks_seen, 1'b1});
        end
      end
      default: begin
        if (int'(c.idx) < TIMER_COUNT) begin
          if (c.cmd == CMD_FREE) begin
            mode_q[c.idx] = MODE_UNUSED;
          end else begin
            mode_q[c.idx] = MODE_RUNNING;
            remain_q[c.idx] = c.timeout;
            reload_q[c.idx] = c.timeout;
            repeats_q[c.idx] = c.repeats;
          end
        end
        due_results.push_back('{'0, 1'b0, 1'b0, ticks_seen, 1'b1});
      end
    endcase
  endtask

  function automatic void check_field(input string what, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  task automatic queue_cmd(input cmd_t c, input logic [RIDX_W-1:0] i,
                           input logic [DATA_W-1:0] t, input logic [DATA_W-1:0] r);
    cmd_backlog.push_back('{c, i, t, r});
  endtask

  // Short timeouts and repeat counts most of the time, full range now and then.
  function automatic logic [DATA_W-1:0] short_or_wide(input int hi);
    if ($urandom_range(0, 7) == 0) return $urandom();
    return $urandom_range(0, hi);
  endfunction

  // Driver: sends the backlog in bursts, predicting each command as it transfers.
  timer_cmd_t cur_cmd;
  int         burst_left;
  int         gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(1, 12);
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) apply_command(cur_cmd);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || cmd_backlog.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          cur_cmd = cmd_backlog.pop_front();
          in_command <= cur_cmd.cmd;
          in_timer_index <= cur_cmd.idx;
          in_timeout_ticks <= cur_cmd.timeout;
          in_repeat_count <= cur_cmd.repeats;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Monitor: checks every result transfer and stalls the output on its own pattern.
  stall_kind_t stall_kind = STALL_OPEN;
  int          stall_seg = 0;

  always @(posedge clk) begin
    timer_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual index %0h expired %0b",
                   $time, out_result_index, out_expired);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("result_index", want.ridx, out_result_index);
          check_field("expired", want.expired, out_expired);
          check_field("status", want.status, out_status);
          check_field("tick_total", want.ticks, out_tick_total);
          check_field("last", want.last, out_last);
        end
      end
      if (stall_seg == 0) begin
        stall_kind = stall_kind_t'($urandom_range(0, 2));
        stall_seg = $urandom_range(1, (stall_kind == STALL_HELD) ? 6 : 30);
      end
      stall_seg--;
      case (stall_kind)
        STALL_OPEN:   out_stall <= 1'b0;
        STALL_CHOPPY: out_stall <= 1'($urandom_range(0, 1));
        default:      out_stall <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("countdown_timer_bank_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          base;
    int          kind;
    int          cnt;
    logic        same_period;
    logic [31:0] fill_tmo;

    for (int i = 0; i < TIMER_COUNT; i++) begin
      mode_q[i] = MODE_UNUSED;
      remain_q[i] = '0;
      reload_q[i] = '0;
      repeats_q[i] = '0;
    end
    ticks_seen = '0;

    // Directed opening: idle tick, allocation order, zero and full-scale timeouts,
    // reloads, free of running and unused timers, and a set on an unused timer.
    queue_cmd(CMD_TICK, RIDX_W'($urandom()), $urandom(), $urandom());
    queue_cmd(CMD_ALLOC, RIDX_W'($urandom()), $urandom(), $urandom());
    queue_cmd(CMD_ALLOC, RIDX_W'($urandom()), $urandom(), $urandom());
    queue_cmd(CMD_SET, 4'd15, 32'd0, 32'd0);
    queue_cmd(CMD_SET, 4'd0, 32'd1, 32'd2);
    queue_cmd(CMD_SET, 4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(CMD_SET, 4'd4, 32'd2, 32'd0);
    queue_cmd(CMD_TICK, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(CMD_FREE, 4'd1, 32'd0, 32'd0);
    queue_cmd(CMD_FREE, 4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_cmd(CMD_TICK, 4'd0, 32'd0, 32'd0);
    queue_cmd(CMD_TICK, RIDX_W'($urandom()), $urandom(), $urandom());
    queue_cmd(CMD_TICK, RIDX_W'($urandom()), $urandom(), $urandom());
    queue_cmd(CMD_ALLOC, RIDX_W'($urandom()), $urandom(), $urandom());
    queue_cmd(CMD_SET, 4'd0, 32'd1, 32'd0);
    queue_cmd(CMD_FREE, 4'd15, 32'd0, 32'd0);
    queue_cmd(CMD_TICK, RIDX_W'($urandom()), $urandom(), $urandom());
    base = cmd_backlog.size();

    // The first random sequence fills the whole bank so that allocation fails
    // and, when every period is one tick, all timers expire on the same tick.
    kind = 8;
    while (cmd_backlog.size() < base + RANDOM_ITEMS) begin
      case (kind)
        0, 1, 2, 3: begin
          cnt = $urandom_range(1, 4);
          repeat (cnt) begin
            queue_cmd(CMD_SET, RIDX_W'($urandom()), short_or_wide(4), short_or_wide(3));
          end
          cnt = $urandom_range(1, 5);
          repeat (cnt) queue_cmd(CMD_TICK, RIDX_W'($urandom()), $urandom(), $urandom());
        end
        4, 5: begin
          cnt = $urandom_range(1, 4);
          repeat (cnt) queue_cmd(CMD_TICK, RIDX_W'($urandom()), $urandom(), $urandom());
        end
        6: begin
          cnt = $urandom_range(1, 3);
          repeat (cnt) queue_cmd(CMD_ALLOC, RIDX_W'($urandom()), $urandom(), $urandom());
        end
        7: begin
          cnt = $urandom_range(1, 2);
          repeat (cnt) queue_cmd(CMD_FREE, RIDX_W'($urandom()), $urandom(), $urandom());
        end
        8: begin
          same_period = ($urandom_range(0, 1) == 1);
          for (int i = 0; i < TIMER_COUNT; i++) begin
            fill_tmo = same_period ? 32'd1 : 32'($urandom_range(1, 3));
            queue_cmd(CMD_SET, RIDX_W'(i), fill_tmo, $urandom_range(0, 2));
          end
          queue_cmd(CMD_ALLOC, RIDX_W'($urandom()), $urandom(), $urandom());
          repeat (3) queue_cmd(CMD_TICK, RIDX_W'($urandom()), $urandom(), $urandom());
        end
        default: begin
          queue_cmd(cmd_t'($urandom_range(0, 3)), RIDX_W'($urandom()), $urandom(),
                    $urandom());
        end
      endcase
      kind = ($urandom_range(0, 19) == 0) ? 8 : $urandom_range(0, 9);
      if (kind == 8) kind = 9;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || in_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (2 * TIMER_COUNT + 8) @(posedge clk);

    if (fail_count == 0) begin
      $display("countdown_timer_bank_top regression: pass");
    end else begin
      $display("countdown_timer_bank_top regression: fail");
    end
    $finish;
  end

endmodule
